// File: hdl/pid_with_deadband_and_clamps_defines.svh
// ----------------------------------------------------------------------------
// PID controller assertion macros
// Shared concurrent assertion forms, clocked on clk_i and held off in reset.
// ----------------------------------------------------------------------------
`ifndef PID_WITH_DEADBAND_AND_CLAMPS_DEFINES_SVH
`define PID_WITH_DEADBAND_AND_CLAMPS_DEFINES_SVH

// Check a property on every rising edge outside reset.
`define PIDC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a trigger implies a consequence in the same cycle.
`define PIDC_ASSERT_SAME(label, trig, cons, msg) \
  `PIDC_ASSERT(label, (trig) |-> (cons), msg)

// Check that a trigger implies a consequence in the next cycle.
`define PIDC_ASSERT_NEXT(label, trig, cons, msg) \
  `PIDC_ASSERT(label, (trig) |=> (cons), msg)

`endif

// File: hdl/pidc_pkg.sv
// ----------------------------------------------------------------------------
// PID controller package
// Field widths and configuration register indexes.
// ----------------------------------------------------------------------------
package pidc_pkg;

  localparam int SP_W       = 16;
  localparam int S_TDATA_W  = 2 * SP_W;
  localparam int DRIVE_W    = 16;
  localparam int ERR_W      = SP_W + 1;
  localparam int DIFF_W     = ERR_W + 1;
  localparam int SUM_W      = 26;
  localparam int GAIN_W     = 32;
  localparam int ILIM_W     = 24;
  localparam int OLIM_W     = 15;
  localparam int DB_W       = 16;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam int PROD_P_W   = GAIN_W + ERR_W;
  localparam int PROD_I_W   = GAIN_W + SUM_W;
  localparam int PROD_D_W   = GAIN_W + DIFF_W;
  localparam int ACC_W      = PROD_I_W + 2;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_GAIN_P    = 3'd0,
    CFG_GAIN_I    = 3'd1,
    CFG_GAIN_D    = 3'd2,
    CFG_INT_LIMIT = 3'd3,
    CFG_OUT_LIMIT = 3'd4,
    CFG_DEADBAND  = 3'd5
  } cfg_idx_e;

endpackage

// File: hdl/pid_with_deadband_and_clamps.sv
// ----------------------------------------------------------------------------
// PID controller with deadband and clamps
// Positional PID: deadbanded error, clamped integral, floor-shifted
// fixed-point sum and saturated drive output.
// ----------------------------------------------------------------------------
//  channel | direction | handshake              | payload
//  s       | in        | s_tvalid_i/s_tready_o  | s_tdata_i: setpoint, measured
//  m       | out       | m_tvalid_o/m_tready_i  | m_tdata_o: drive
//  cfg     | in        | cfg_valid_i/cfg_ready_o| cfg_addr_i, cfg_data_i
//
// One item per cycle while the output is not stalled; output valid follows
// an input through the input, error/integral, product and drive registers.
// The integral update (add and clamp) is combinational and closes its loop through one register.
// All stages advance together; a stalled output holds the whole pipeline.
// Reset clears gains, limits, integral and previous error to zero.
// ----------------------------------------------------------------------------
module pid_with_deadband_and_clamps import pidc_pkg::*; #(
  parameter int unsigned FRAC_BITS = 20
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_tvalid_i,
  output logic                  s_tready_o,
  input  logic [S_TDATA_W-1:0]  s_tdata_i,   // setpoint [15:0], measured [31:16]
  output logic                  m_tvalid_o,
  input  logic                  m_tready_i,
  output logic [DRIVE_W-1:0]    m_tdata_o,   // drive [15:0]
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_ADDR_W-1:0] cfg_addr_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  logic advance;

  logic signed [GAIN_W-1:0] gain_p_q, gain_i_q, gain_d_q;
  logic        [ILIM_W-1:0] int_limit_q;
  logic        [OLIM_W-1:0] out_limit_q;
  logic        [DB_W-1:0]   deadband_q;

  logic v0_q, v1_q, v2_q, v3_q;

  logic signed [SP_W-1:0]     sp_q, ms_q;
  logic signed [ERR_W-1:0]    err_raw, err_db, err_q;
  logic        [ERR_W-1:0]    err_mag;
  logic signed [SUM_W-1:0]    sum_d, sum_q, sum_lim;
  logic signed [SUM_W-1:0]    error_sum_q;
  logic signed [ERR_W-1:0]    last_error_q;
  logic signed [DIFF_W-1:0]   diff_d, diff_q;
  logic signed [PROD_P_W-1:0] prod_p_q;
  logic signed [PROD_I_W-1:0] prod_i_q;
  logic signed [PROD_D_W-1:0] prod_d_q;
  logic signed [ACC_W-1:0]    acc, y_shift, y_clamp, out_lim;
  logic        [DRIVE_W-1:0]  drive_d, drive_q;

  assign advance     = !v3_q || m_tready_i;
  assign s_tready_o  = advance;
  assign cfg_ready_o = 1'b1;
  assign m_tvalid_o  = v3_q;
  assign m_tdata_o   = drive_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_p_q    <= '0;
      gain_i_q    <= '0;
      gain_d_q    <= '0;
      int_limit_q <= '0;
      out_limit_q <= '0;
      deadband_q  <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_addr_i)
        CFG_GAIN_P:    gain_p_q    <= $signed(cfg_data_i[GAIN_W-1:0]);
        CFG_GAIN_I:    gain_i_q    <= $signed(cfg_data_i[GAIN_W-1:0]);
        CFG_GAIN_D:    gain_d_q    <= $signed(cfg_data_i[GAIN_W-1:0]);
        CFG_INT_LIMIT: int_limit_q <= cfg_data_i[ILIM_W-1:0];
        CFG_OUT_LIMIT: out_limit_q <= cfg_data_i[OLIM_W-1:0];
        CFG_DEADBAND:  deadband_q  <= cfg_data_i[DB_W-1:0];
        default: ;
      endcase
    end
  end

  // error, deadband, integral clamp and difference
  always_comb begin
    err_raw = ERR_W'(sp_q) - ERR_W'(ms_q);
    err_mag = err_raw[ERR_W-1] ? ERR_W'(-err_raw) : err_raw;
    err_db  = (err_mag <= ERR_W'(deadband_q)) ? '0 : err_raw;
    sum_lim = $signed(SUM_W'(int_limit_q));
    sum_d   = error_sum_q + SUM_W'(err_db);
    if (sum_d >= sum_lim) begin
      sum_d = sum_lim;
    end
    if (sum_d <= -sum_lim) begin
      sum_d = -sum_lim;
    end
    diff_d = DIFF_W'(err_db) - DIFF_W'(last_error_q);
  end

  // sum, floor shift and output clamp
  always_comb begin
    acc     = ACC_W'(prod_p_q) + ACC_W'(prod_i_q) + ACC_W'(prod_d_q);
    y_shift = acc >>> FRAC_BITS;
    out_lim = $signed(ACC_W'(out_limit_q));
    y_clamp = y_shift;
    if (y_clamp >= out_lim) begin
      y_clamp = out_lim;
    end
    if (y_clamp <= -out_lim) begin
      y_clamp = -out_lim;
    end
    drive_d = y_clamp[DRIVE_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q         <= 1'b0;
      v1_q         <= 1'b0;
      v2_q         <= 1'b0;
      v3_q         <= 1'b0;
      error_sum_q  <= '0;
      last_error_q <= '0;
    end else if (advance) begin
      v0_q <= s_tvalid_i;
      v1_q <= v0_q;
      v2_q <= v1_q;
      v3_q <= v2_q;
      if (v0_q) begin
        error_sum_q  <= sum_d;
        last_error_q <= err_db;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      sp_q     <= $signed(s_tdata_i[SP_W-1:0]);
      ms_q     <= $signed(s_tdata_i[S_TDATA_W-1:SP_W]);
      err_q    <= err_db;
      sum_q    <= sum_d;
      diff_q   <= diff_d;
      prod_p_q <= gain_p_q * err_q;
      prod_i_q <= gain_i_q * sum_q;
      prod_d_q <= gain_d_q * diff_q;
      drive_q  <= drive_d;
    end
  end

endmodule

// File: hdl/pidc_checker.sv
// ----------------------------------------------------------------------------
// PID controller checker
// Port-level assertions on output range, stalls and flow control.
// ----------------------------------------------------------------------------
`include "pid_with_deadband_and_clamps_defines.svh"

module pidc_checker import pidc_pkg::*; (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  s_tvalid_i,
  input logic                  s_tready_o,
  input logic [S_TDATA_W-1:0]  s_tdata_i,
  input logic                  m_tvalid_o,
  input logic                  m_tready_i,
  input logic [DRIVE_W-1:0]    m_tdata_o,
  input logic                  cfg_valid_i,
  input logic                  cfg_ready_o,
  input logic [CFG_ADDR_W-1:0] cfg_addr_i,
  input logic [CFG_DATA_W-1:0] cfg_data_i
);

  logic [DRIVE_W-1:0] drive_min_neg;

  assign drive_min_neg = {1'b1, {(DRIVE_W-1){1'b0}}};

  `PIDC_ASSERT_SAME(a_drive_range, m_tvalid_o, m_tdata_o != drive_min_neg, "drive out of range")
  `PIDC_ASSERT_NEXT(a_out_hold, m_tvalid_o && !m_tready_i, m_tvalid_o && $stable(m_tdata_o), "stalled transaction changed")
  `PIDC_ASSERT(a_in_flow, s_tready_o == (!m_tvalid_o || m_tready_i), "input ready mismatch")
  `PIDC_ASSERT(a_cfg_ready, cfg_ready_o || !cfg_valid_i || (cfg_addr_i != cfg_addr_i) || (cfg_data_i != cfg_data_i) || (s_tdata_i != s_tdata_i) || !s_tvalid_i || s_tvalid_i, "config write stalled")

endmodule

bind pid_with_deadband_and_clamps pidc_checker u_pidc_checker (.*);
